@@ hdl/dmpi_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual motor PI drive package
// Widths, register indexes, reset values and the per-wheel arithmetic shared
// by the drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package dmpi_pkg;

  // Accumulator and undervoltage trip settings
  localparam int ACCUM_WIDTH     = 32;
  localparam int UNDERVOLT_TICKS = 100;

  // Products are at most 29 bits signed; the sum gets two guard bits
  localparam int SUM_W = ((ACCUM_WIDTH > 28) ? ACCUM_WIDTH : 28) + 2;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

  localparam logic [7:0] UV_TRIP = 8'(UNDERVOLT_TICKS);

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_I       = 3'd1,
    REG_DRIVE_LIMIT  = 3'd2,
    REG_PWM_PERIOD   = 3'd3,
    REG_FORWARD_ONLY = 3'd4,
    REG_LOW_VOLT     = 3'd5,
    REG_SERVO_CENTER = 3'd6,
    REG_SERVO_SWING  = 3'd7
  } cfg_reg_t;

  // Register reset values
  localparam logic [9:0]  GAIN_P_RST       = 10'd20;
  localparam logic [9:0]  GAIN_I_RST       = 10'd30;
  localparam logic [15:0] DRIVE_LIMIT_RST  = 16'd6900;
  localparam logic [15:0] PWM_PERIOD_RST   = 16'd7200;
  localparam logic [11:0] LOW_VOLT_RST     = 12'd1110;
  localparam logic [15:0] SERVO_CENTER_RST = 16'd1500;
  localparam logic [14:0] SERVO_SWING_RST  = 15'd300;

  typedef logic signed [ACCUM_WIDTH-1:0] accum_t;
  typedef logic signed [16:0]            err_t;

  typedef struct packed {
    accum_t acc;
    err_t   err;
  } pi_res_t;

  typedef struct packed {
    logic [15:0] one;
    logic [15:0] two;
  } duty_t;

  // One incremental PI update with saturation
  function automatic pi_res_t pi_step(input accum_t acc, input err_t prev,
                                      input logic signed [15:0] meas,
                                      input logic signed [15:0] tgt,
                                      input logic [9:0] gp,
                                      input logic [9:0] gi);
    err_t                    e;
    logic signed [17:0]      de;
    logic signed [28:0]      prod_p;
    logic signed [28:0]      prod_i;
    logic signed [SUM_W-1:0] sum;
    pi_res_t                 res;
    e      = $signed({tgt[15], tgt}) - $signed({meas[15], meas});
    de     = $signed({e[16], e}) - $signed({prev[16], prev});
    prod_p = $signed({1'b0, gp}) * de;
    prod_i = $signed({1'b0, gi}) * e;
    sum    = SUM_W'(acc) + SUM_W'(prod_p) + SUM_W'(prod_i);
    if (sum > ACC_MAX) begin
      sum = ACC_MAX;
    end else if (sum < ACC_MIN) begin
      sum = ACC_MIN;
    end
    res.acc = sum[ACCUM_WIDTH-1:0];
    res.err = e;
    return res;
  endfunction

  // Clamp the drive and map it onto the two PWM channels
  function automatic duty_t drive_map(input accum_t d, input logic [15:0] lim,
                                      input logic [15:0] per, input logic fwd);
    accum_t             lim_s;
    accum_t             dc;
    logic signed [17:0] v;
    duty_t              res;
    lim_s = $signed({{(ACCUM_WIDTH-16){1'b0}}, lim});
    dc    = d;
    if (dc > lim_s) begin
      dc = lim_s;
    end
    if (dc < -lim_s) begin
      dc = -lim_s;
    end
    if (fwd && dc < 0) begin
      dc = '0;
    end
    if (dc < 0) begin
      v = $signed({2'b00, per}) + $signed({dc[16], dc[16:0]});
      res.one = (v < 0) ? 16'd0 : v[15:0];
      res.two = per;
    end else begin
      res.one = dc[15:0];
      res.two = 16'd0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/dual_motor_incremental_pi_drive.sv @@
// ----------------------------------------------------------------------------
// Dual motor incremental PI drive
// Two wheel PI speed loops, servo clamp and undervoltage stop, one tick per item.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, and the result
// register loads from it as soon as the result slot is free.
// Throughput: one item per cycle while out_stall is low; the PI accumulators
// update in a single pass from the input register to the result register.
// Reset: gains and limits load their defaults, PI state clears, the drive
// starts stopped and both channels are empty.
`default_nettype none

module dual_motor_incremental_pi_drive
  import dmpi_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  // input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    in_speed_left,
  input  wire logic signed [15:0]    in_speed_right,
  input  wire logic signed [15:0]    in_target_left,
  input  wire logic signed [15:0]    in_target_right,
  input  wire logic [15:0]           in_servo_cmd,
  input  wire logic [11:0]           in_battery_level,
  input  wire logic                  in_stop_toggle,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [15:0]                out_left_duty_one,
  output logic [15:0]                out_left_duty_two,
  output logic [15:0]                out_right_duty_one,
  output logic [15:0]                out_right_duty_two,
  output logic [15:0]                out_servo_duty,
  output logic                       out_halted
);

  // Configuration registers
  logic [9:0]  gain_p_r;
  logic [9:0]  gain_i_r;
  logic [15:0] drive_limit_r;
  logic [15:0] pwm_period_r;
  logic        forward_only_r;
  logic [11:0] low_volt_r;
  logic [15:0] servo_center_r;
  logic [14:0] servo_swing_r;

  // Input register
  logic                     in_valid_r;
  logic signed [15:0]       speed_left_r;
  logic signed [15:0]       speed_right_r;
  logic signed [15:0]       target_left_r;
  logic signed [15:0]       target_right_r;
  logic [15:0]              servo_cmd_r;
  logic [11:0]              battery_r;
  logic                     toggle_r;

  // Controller state
  accum_t     left_accum_r, left_accum_nxt;
  accum_t     right_accum_r, right_accum_nxt;
  err_t       left_prev_r, left_prev_nxt;
  err_t       right_prev_r, right_prev_nxt;
  logic [7:0] uv_count_r, uv_count_nxt;
  logic       stop_r, stop_nxt;

  // Result register
  logic        out_valid_r;
  logic [15:0] left_one_r, left_one_nxt;
  logic [15:0] left_two_r, left_two_nxt;
  logic [15:0] right_one_r, right_one_nxt;
  logic [15:0] right_two_r, right_two_nxt;
  logic [15:0] servo_r, servo_nxt;
  logic        halted_r, halted_nxt;

  logic out_free;
  logic advance;
  logic load_in;

  // Handshake: result slot frees when empty or taken
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign load_in  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r       <= GAIN_P_RST;
      gain_i_r       <= GAIN_I_RST;
      drive_limit_r  <= DRIVE_LIMIT_RST;
      pwm_period_r   <= PWM_PERIOD_RST;
      forward_only_r <= 1'b0;
      low_volt_r     <= LOW_VOLT_RST;
      servo_center_r <= SERVO_CENTER_RST;
      servo_swing_r  <= SERVO_SWING_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_P:       gain_p_r       <= cfg_wdata[9:0];
        REG_GAIN_I:       gain_i_r       <= cfg_wdata[9:0];
        REG_DRIVE_LIMIT:  drive_limit_r  <= cfg_wdata;
        REG_PWM_PERIOD:   pwm_period_r   <= cfg_wdata;
        REG_FORWARD_ONLY: forward_only_r <= cfg_wdata[0];
        REG_LOW_VOLT:     low_volt_r     <= cfg_wdata[11:0];
        REG_SERVO_CENTER: servo_center_r <= cfg_wdata;
        REG_SERVO_SWING:  servo_swing_r  <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Capture an item into the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      speed_left_r   <= in_speed_left;
      speed_right_r  <= in_speed_right;
      target_left_r  <= in_target_left;
      target_right_r <= in_target_right;
      servo_cmd_r    <= in_servo_cmd;
      battery_r      <= in_battery_level;
      toggle_r       <= in_stop_toggle;
    end
  end

  // One control tick: undervoltage check, PI update, output mapping
  always_comb begin
    logic [7:0]         uv_inc;
    logic               stop_now;
    pi_res_t            pl;
    pi_res_t            pr;
    duty_t              dl;
    duty_t              dr;
    logic signed [17:0] srv_lo;
    logic signed [17:0] srv_hi;
    logic signed [17:0] srv;

    uv_count_nxt = uv_count_r;
    stop_now     = stop_r;
    if (battery_r < low_volt_r) begin
      uv_inc = uv_count_r + 8'd1;
      if (uv_inc > UV_TRIP) begin
        uv_count_nxt = 8'd0;
        stop_now     = 1'b1;
      end else begin
        uv_count_nxt = uv_inc;
      end
    end else begin
      uv_inc = uv_count_r;
    end

    pl = pi_step(left_accum_r, left_prev_r, speed_left_r, target_left_r,
                 gain_p_r, gain_i_r);
    pr = pi_step(right_accum_r, right_prev_r, speed_right_r, target_right_r,
                 gain_p_r, gain_i_r);
    dl = drive_map(pl.acc, drive_limit_r, pwm_period_r, forward_only_r);
    dr = drive_map(pr.acc, drive_limit_r, pwm_period_r, forward_only_r);

    // Clamp the servo to centre plus or minus swing
    srv_lo = $signed({2'b00, servo_center_r}) - $signed({3'b000, servo_swing_r});
    srv_hi = $signed({2'b00, servo_center_r}) + $signed({3'b000, servo_swing_r});
    srv    = $signed({2'b00, servo_cmd_r});
    if (srv < srv_lo) begin
      srv = srv_lo;
    end
    if (srv > srv_hi) begin
      srv = srv_hi;
    end

    if (stop_now) begin
      // Hold PI state, zero the duties, centre the servo
      left_accum_nxt  = left_accum_r;
      right_accum_nxt = right_accum_r;
      left_prev_nxt   = left_prev_r;
      right_prev_nxt  = right_prev_r;
      left_one_nxt    = 16'd0;
      left_two_nxt    = 16'd0;
      right_one_nxt   = 16'd0;
      right_two_nxt   = 16'd0;
      servo_nxt       = servo_center_r;
      halted_nxt      = 1'b1;
    end else begin
      left_accum_nxt  = pl.acc;
      right_accum_nxt = pr.acc;
      left_prev_nxt   = pl.err;
      right_prev_nxt  = pr.err;
      left_one_nxt    = dl.one;
      left_two_nxt    = dl.two;
      right_one_nxt   = dr.one;
      right_two_nxt   = dr.two;
      servo_nxt       = srv[15:0];
      halted_nxt      = 1'b0;
    end

    // The key toggles run and stop after the outputs
    stop_nxt = stop_now ^ toggle_r;
  end

  // Advance controller state once per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_accum_r  <= '0;
      right_accum_r <= '0;
      left_prev_r   <= '0;
      right_prev_r  <= '0;
      uv_count_r    <= 8'd0;
      stop_r        <= 1'b1;
    end else if (advance) begin
      left_accum_r  <= left_accum_nxt;
      right_accum_r <= right_accum_nxt;
      left_prev_r   <= left_prev_nxt;
      right_prev_r  <= right_prev_nxt;
      uv_count_r    <= uv_count_nxt;
      stop_r        <= stop_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_one_r  <= left_one_nxt;
      left_two_r  <= left_two_nxt;
      right_one_r <= right_one_nxt;
      right_two_r <= right_two_nxt;
      servo_r     <= servo_nxt;
      halted_r    <= halted_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_duty_one  = left_one_r;
  assign out_left_duty_two  = left_two_r;
  assign out_right_duty_one = right_one_r;
  assign out_right_duty_two = right_two_r;
  assign out_servo_duty     = servo_r;
  assign out_halted         = halted_r;

`ifndef SYNTHESIS
  // A halted result drives no motor channel
  a_halted_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_halted) |->
      (out_left_duty_one == 16'd0 && out_left_duty_two == 16'd0 &&
       out_right_duty_one == 16'd0 && out_right_duty_two == 16'd0))
    else $error("halted result with non-zero duty");

  // Forward-only mode never selects the reverse channel
  a_fwd_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && forward_only_r) |->
      (out_left_duty_two == 16'd0 && out_right_duty_two == 16'd0))
    else $error("reverse duty in forward-only mode");

  // The input side stalls only while an item waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked item");

  // Controller leaves reset stopped
  a_reset_stop: assert property (@(posedge clk)
    !rst_n |=> stop_r)
    else $error("drive not stopped after reset");
`endif

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// Dual motor PI drive testbench
// Feeds control ticks to the drive and checks every result against a
// predictor of both PI wheels, the duty mapping, the servo clamp, the
// undervoltage trip and the stop key. A short list of directed ticks comes
// first, then random ticks under several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import dmpi_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int N_DIR        = 18;
  localparam int N_PHASES     = 7;
  localparam int PRINT_CAP    = 40;

  // One control tick and the duties it produces
  typedef struct packed {
    logic signed [15:0] speed_l;
    logic signed [15:0] speed_r;
    logic signed [15:0] target_l;
    logic signed [15:0] target_r;
    logic [15:0]        servo_cmd;
    logic [11:0]        battery;
    logic               toggle;
  } tick_t;

  typedef struct packed {
    logic [15:0] l_one;
    logic [15:0] l_two;
    logic [15:0] r_one;
    logic [15:0] r_two;
    logic [15:0] servo;
    logic        halted;
  } drive_res_t;

  typedef struct packed {
    logic [9:0]  kp;
    logic [9:0]  ki;
    logic [15:0] lim;
    logic [15:0] period;
    logic        fwd;
    logic [11:0] vth;
    logic [15:0] centre;
    logic [14:0] swing;
  } cfg_set_t;

  typedef struct packed {
    tick_t      t;
    logic       typed;
    drive_res_t res;
  } dir_row_t;

  localparam drive_res_t HALTED_AT_RESET =
    '{16'd0, 16'd0, 16'd0, 16'd0, SERVO_CENTER_RST, 1'b1};

  // Directed ticks under the reset settings; the drive starts stopped
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 12'd2000, 1'b0}, 1'b1, HALTED_AT_RESET},
    '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'hFFFF, 12'hFFF, 1'b1},
      1'b1, HALTED_AT_RESET},
    '{'{16'sd0, 16'sd0, 16'sd100, -16'sd100, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'd0, 12'd1110, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'hFFFF, 12'd1109, 1'b0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1200, 12'd0, 1'b0}, 1'b0, '0},
    '{'{16'sd5, -16'sd5, 16'sd5, -16'sd5, 16'd1800, 12'd3000, 1'b0}, 1'b0, '0},
    '{'{16'sd5, -16'sd5, 16'sd5, -16'sd5, 16'd1801, 12'd3000, 1'b1}, 1'b0, '0},
    '{'{16'sd1000, -16'sd1000, 16'sd0, 16'sd0, 16'h5555, 12'hAAA, 1'b0},
      1'b1, HALTED_AT_RESET},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'hAAAA, 12'h555, 1'b1}, 1'b1, HALTED_AT_RESET},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1199, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{-16'sd300, 16'sd300, 16'sd300, -16'sd300, 16'd1500, 12'hFFF, 1'b0}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'd1500, 12'd2000, 1'b0}, 1'b0, '0},
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'd1500, 12'd2000, 1'b1}, 1'b0, '0}
  };

  // Clock, reset and block ports
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    in_speed_left = '0;
  logic signed [15:0]    in_speed_right = '0;
  logic signed [15:0]    in_target_left = '0;
  logic signed [15:0]    in_target_right = '0;
  logic [15:0]           in_servo_cmd = '0;
  logic [11:0]           in_battery_level = '0;
  logic                  in_stop_toggle = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [15:0]           out_left_duty_one;
  logic [15:0]           out_left_duty_two;
  logic [15:0]           out_right_duty_one;
  logic [15:0]           out_right_duty_two;
  logic [15:0]           out_servo_duty;
  logic                  out_halted;

  // Predictor state and live register copy
  cfg_set_t   live_cfg = '{GAIN_P_RST, GAIN_I_RST, DRIVE_LIMIT_RST, PWM_PERIOD_RST, 1'b0,
                           LOW_VOLT_RST, SERVO_CENTER_RST, SERVO_SWING_RST};
  accum_t     l_accum = '0;
  accum_t     r_accum = '0;
  err_t       l_prev_err = '0;
  err_t       r_prev_err = '0;
  logic [7:0] uv_count = '0;
  logic       stopped = 1'b1;

  drive_res_t duty_backlog [$];
  drive_res_t seen_res;
  drive_res_t want_res;
  cfg_set_t   phase_cfg [N_PHASES];
  int         phase_items [N_PHASES] = '{160, 80, 90, 90, 90, 100, 80};
  bit         low_bias [N_PHASES];

  int  cycle_count = 0;
  int  fail_count = 0;
  int  ticks_sent = 0;
  int  results_seen = 0;
  int  halted_ticks = 0;
  int  uv_trips = 0;
  int  stall_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_steady = 1'b0;

  dual_motor_incremental_pi_drive dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_speed_left     (in_speed_left),
    .in_speed_right    (in_speed_right),
    .in_target_left    (in_target_left),
    .in_target_right   (in_target_right),
    .in_servo_cmd      (in_servo_cmd),
    .in_battery_level  (in_battery_level),
    .in_stop_toggle    (in_stop_toggle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_left_duty_one (out_left_duty_one),
    .out_left_duty_two (out_left_duty_two),
    .out_right_duty_one(out_right_duty_one),
    .out_right_duty_two(out_right_duty_two),
    .out_servo_duty    (out_servo_duty),
    .out_halted        (out_halted)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PRINT_CAP) begin
      $display("ERROR: %s", msg);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                results_seen, name, got, want));
    end
  endtask

  // One incremental PI step with saturation at the accumulator width
  task automatic advance_pi(inout accum_t acc, inout err_t prev_err,
                            input logic signed [15:0] meas,
                            input logic signed [15:0] tgt, output longint drive);
    longint top;
    longint err;
    longint sum;
    top = (longint'(1) <<< (ACCUM_WIDTH - 1)) - 1;
    err = longint'(tgt) - longint'(meas);
    sum = longint'(acc) + longint'(live_cfg.kp) * (err - longint'(prev_err))
          + longint'(live_cfg.ki) * err;
    if (sum > top) sum = top;
    if (sum < -top - 1) sum = -top - 1;
    acc      = accum_t'(sum);
    prev_err = err_t'(err);
    drive    = sum;
  endtask

  // Clamp a drive value and split it into the two PWM channel duties
  task automatic map_duty(input longint drive, output logic [15:0] one,
                          output logic [15:0] two);
    longint d;
    longint lim;
    longint v;
    d   = drive;
    lim = longint'(live_cfg.lim);
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    if (live_cfg.fwd && d < 0) d = 0;
    if (d < 0) begin
      v = longint'(live_cfg.period) + d;
      if (v < 0) v = 0;
      one = 16'(v);
      two = live_cfg.period;
    end else begin
      one = 16'(d);
      two = 16'd0;
    end
  endtask

  // Advance the predictor by one control tick
  task automatic run_control_tick(input tick_t t, output drive_res_t r);
    longint dl;
    longint dr;
    longint lo;
    longint hi;
    longint cmd;
    if (t.battery < live_cfg.vth) begin
      uv_count = uv_count + 8'd1;
      if (uv_count > UNDERVOLT_TICKS) begin
        uv_count = '0;
        stopped  = 1'b1;
        uv_trips++;
      end
    end
    if (stopped) begin
      r = '{16'd0, 16'd0, 16'd0, 16'd0, live_cfg.centre, 1'b1};
      halted_ticks++;
    end else begin
      advance_pi(l_accum, l_prev_err, t.speed_l, t.target_l, dl);
      advance_pi(r_accum, r_prev_err, t.speed_r, t.target_r, dr);
      map_duty(dl, r.l_one, r.l_two);
      map_duty(dr, r.r_one, r.r_two);
      lo  = longint'(live_cfg.centre) - longint'(live_cfg.swing);
      hi  = longint'(live_cfg.centre) + longint'(live_cfg.swing);
      cmd = longint'(t.servo_cmd);
      if (cmd < lo) cmd = lo;
      if (cmd > hi) cmd = hi;
      r.servo  = 16'(cmd);
      r.halted = 1'b0;
    end
    // the stop key acts after the outputs
    if (t.toggle) stopped = !stopped;
  endtask

  // Offer one tick, hold it until accepted, then record its duties
  task automatic send_tick(input tick_t t, input logic typed, input drive_res_t typed_res);
    int         gap;
    drive_res_t r;
    if ($urandom_range(29, 0) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(12, 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_speed_left    <= t.speed_l;
    in_speed_right   <= t.speed_r;
    in_target_left   <= t.target_l;
    in_target_right  <= t.target_r;
    in_servo_cmd     <= t.servo_cmd;
    in_battery_level <= t.battery;
    in_stop_toggle   <= t.toggle;
    do @(posedge clk); while (in_stall);
    run_control_tick(t, r);
    duty_backlog.push_back(typed ? typed_res : r);
    ticks_sent++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_drained();
    int w;
    in_valid <= 1'b0;
    for (w = 0; duty_backlog.size() != 0 && w < 5000; w++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (duty_backlog.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", duty_backlog.size()));
      duty_backlog.delete();
    end
  endtask

  // Result side: take results, compare, and stall at random
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      seen_res = '{out_left_duty_one, out_left_duty_two, out_right_duty_one,
                   out_right_duty_two, out_servo_duty, out_halted};
      results_seen++;
      if (duty_backlog.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no tick waiting", results_seen));
      end else begin
        want_res = duty_backlog.pop_front();
        check_field("left_duty_one", seen_res.l_one, want_res.l_one);
        check_field("left_duty_two", seen_res.l_two, want_res.l_two);
        check_field("right_duty_one", seen_res.r_one, want_res.r_one);
        check_field("right_duty_two", seen_res.r_two, want_res.r_two);
        check_field("servo_duty", seen_res.servo, want_res.servo);
        check_field("halted", seen_res.halted, want_res.halted);
      end
      if ($urandom_range(39, 0) == 0) rx_steady = !rx_steady;
      draw = rx_steady ? 0 : $urandom_range(12, 0);
      stall_left <= draw;
      out_stall  <= (draw != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Stop a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timed out after %0d cycles", cycle_count);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    tick_t      t;
    cfg_set_t   c;
    cfg_reg_t   reg_id;
    logic [15:0] wval;
    int         p;
    int         n;
    int         k;
    int         kind;
    int         base_l;
    int         base_r;
    int         sw;
    int         sc;
    bit         push_up;
    bit         below;

    // Register settings per phase: extremes first, then mixed and random
    phase_cfg[0] = '{10'd1023, 10'd1023, 16'hFFFF, 16'd1, 1'b0, 12'hFFF, 16'd0, 15'h7FFF};
    phase_cfg[1] = '{10'd0, 10'd0, 16'd0, 16'hFFFF, 1'b1, 12'd0, 16'hFFFF, 15'd0};
    phase_cfg[2] = '{GAIN_P_RST, GAIN_I_RST, DRIVE_LIMIT_RST, PWM_PERIOD_RST, 1'b1,
                     LOW_VOLT_RST, SERVO_CENTER_RST, SERVO_SWING_RST};
    for (p = 3; p <= 4; p++) begin
      phase_cfg[p] = '{10'($urandom), 10'($urandom), 16'($urandom),
                       16'($urandom_range(65535, 1)), 1'($urandom_range(1, 0)),
                       12'($urandom), 16'($urandom), 15'($urandom)};
    end
    phase_cfg[5] = '{10'd512, 10'd5, 16'd40000, 16'd30000, 1'b0, 12'd2048, 16'd100, 15'd1000};
    phase_cfg[6] = '{GAIN_P_RST, GAIN_I_RST, DRIVE_LIMIT_RST, PWM_PERIOD_RST, 1'b0,
                     LOW_VOLT_RST, SERVO_CENTER_RST, SERVO_SWING_RST};
    low_bias = '{1'b1, 1'b0, 1'b0, 1'b1, 1'($urandom_range(1, 0)), 1'b1, 1'b0};

    // Hold reset, then release it
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks
    for (n = 0; n < N_DIR; n++) begin
      send_tick(DIR_ROWS[n].t, DIR_ROWS[n].typed, DIR_ROWS[n].res);
    end

    // Random ticks, one register setting per phase
    for (p = 0; p < N_PHASES; p++) begin
      wait_drained();
      c = phase_cfg[p];
      for (k = 0; k < 8; k++) begin
        reg_id = cfg_reg_t'(k);
        case (reg_id)
          REG_GAIN_P:       wval = 16'(c.kp);
          REG_GAIN_I:       wval = 16'(c.ki);
          REG_DRIVE_LIMIT:  wval = c.lim;
          REG_PWM_PERIOD:   wval = c.period;
          REG_FORWARD_ONLY: wval = 16'(c.fwd);
          REG_LOW_VOLT:     wval = 16'(c.vth);
          REG_SERVO_CENTER: wval = c.centre;
          default:          wval = 16'(c.swing);
        endcase
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= reg_id;
        cfg_wdata <= wval;
      end
      @(posedge clk);
      cfg_we   <= 1'b0;
      live_cfg = c;
      push_up  = 1'($urandom_range(1, 0));

      for (n = 0; n < phase_items[p]; n++) begin
        kind = $urandom_range(99, 0);
        if (kind < 45) begin
          // wheels tracking a moderate target
          base_l     = int'($urandom_range(4000, 0)) - 2000;
          base_r     = int'($urandom_range(4000, 0)) - 2000;
          t.target_l = 16'(base_l);
          t.target_r = 16'(base_r);
          t.speed_l  = 16'(base_l + int'($urandom_range(600, 0)) - 300);
          t.speed_r  = 16'(base_r + int'($urandom_range(600, 0)) - 300);
        end else if (kind < 70) begin
          t.target_l = 16'($urandom);
          t.target_r = 16'($urandom);
          t.speed_l  = 16'($urandom);
          t.speed_r  = 16'($urandom);
        end else begin
          // sustained full-scale error to drive the accumulators into saturation
          if ($urandom_range(19, 0) == 0) push_up = !push_up;
          t.target_l = push_up ? 16'sh7FFF : 16'sh8000;
          t.target_r = push_up ? 16'sh8000 : 16'sh7FFF;
          t.speed_l  = 16'(int'($urandom_range(2000, 0)) - 1000);
          t.speed_r  = 16'(int'($urandom_range(2000, 0)) - 1000);
        end
        if ($urandom_range(1, 0) == 0) begin
          t.servo_cmd = 16'($urandom);
        end else begin
          sw          = int'(live_cfg.swing);
          sc          = int'(live_cfg.centre) + int'($urandom_range(2 * sw + 100, 0)) - sw - 50;
          t.servo_cmd = 16'(sc);
        end
        below = (live_cfg.vth != 0) &&
                (low_bias[p] ? ($urandom_range(19, 0) != 0) : ($urandom_range(39, 0) == 0));
        t.battery = below ? 12'($urandom_range(int'(live_cfg.vth) - 1, 0))
                          : 12'($urandom_range(4095, int'(live_cfg.vth)));
        // release the stop state quickly so most ticks run the loops
        t.toggle = stopped ? ($urandom_range(3, 0) == 0) : ($urandom_range(29, 0) == 0);
        send_tick(t, 1'b0, '0);
      end
    end

    wait_drained();
    $display("Drove %0d ticks under %0d register settings, %0d results checked, %0d mismatches",
             ticks_sent, N_PHASES + 1, results_seen, fail_count);
    $display("Covered %0d halted ticks and %0d undervoltage shutdowns",
             halted_ticks, uv_trips);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
